/* rtl/ptnp_pkg.sv */
// Shared widths, payload structs and controller/datapath interface types.
`default_nettype none
package ptnp_pkg;

    // Operand width and the width of an unsigned result value
    localparam int DATA_WIDTH = 32;
    localparam int VAL_W      = DATA_WIDTH - 1;

    // Largest value the result field holds
    localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

    // Operation select codes
    localparam logic FUNC_TEST = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    // Input item
    typedef struct packed {
        logic                         func;
        logic signed [DATA_WIDTH-1:0] number;
    } t_in;

    // Result item
    typedef struct packed {
        logic             prime_flag;
        logic [VAL_W-1:0] value;
        logic             overflow;
    } t_out;

    // Divisor source for the next trial division
    typedef enum logic {
        DS_D,
        DS_D2
    } t_dsel;

    // Kind of result to emit
    typedef enum logic [1:0] {
        FIN_TEST,
        FIN_NEXT,
        FIN_TWO,
        FIN_OVF
    } t_fin;

    // Controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  inc_cand;
        logic  div_go;
        t_dsel div_sel;
        logic  set_d5;
        logic  add_d6;
        logic  finish;
        t_fin  fin;
        logic  prime;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mode;
        logic c_lt2;
        logic c_le3;
        logic c_even;
        logic c_mult3;
        logic c_at_max;
        logic c_over;
        logic div_done;
        logic rem_zero;
        logic d_gt_q;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/ptnp_div.sv */
// Restoring divider: one quotient bit per cycle, quotient and remainder out.
`default_nettype none
module ptnp_div
    import ptnp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [VAL_W-1:0] i_dividend,
    input  wire logic [VAL_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [VAL_W-1:0] o_quot,
    output logic      [VAL_W-1:0] o_rem
);

    localparam int CW = $clog2(VAL_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [VAL_W-1:0] r_n, n_n;
    logic [VAL_W-1:0] r_q, n_q;
    logic [VAL_W-1:0] r_rem, n_rem;
    logic [VAL_W-1:0] r_dv, n_dv;
    logic [VAL_W:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and try the subtract
    assign trial = {r_rem, r_n[VAL_W-1]};
    assign fits  = trial >= {1'b0, r_dv};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_n    = r_n;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dv   = r_dv;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = CW'(VAL_W - 1);
            n_n    = i_dividend;
            n_q    = '0;
            n_rem  = '0;
            n_dv   = i_divisor;
        end else if (r_busy) begin
            n_n   = {r_n[VAL_W-2:0], 1'b0};
            n_q   = {r_q[VAL_W-2:0], fits};
            n_rem = fits ? VAL_W'(trial - {1'b0, r_dv}) : trial[VAL_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control in reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_n   <= n_n;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dv  <= n_dv;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

/* rtl/ptnp_dp.sv */
// Datapath: candidate and divisor registers, divider, result register.
`default_nettype none
module ptnp_dp
    import ptnp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_in   i_item,
    input  wire t_cmd  i_cmd,
    output t_stat      o_stat,
    output logic       o_valid,
    output t_out       o_result
);

    // Base-4 digits in the candidate
    localparam int NDIG = (VAL_W + 1) / 2;

    logic             r_mode;
    logic [VAL_W:0]   r_c;
    logic [VAL_W-1:0] r_d;
    logic             r_valid;
    t_out             r_result, n_result;
    logic [VAL_W-1:0] divisor;
    logic             div_done;
    logic [VAL_W-1:0] quot, rem;
    logic [1:0]       c_res3;

    // Residue mod 3: each base-4 digit keeps its residue, then a pairwise add tree
    function automatic logic [1:0] mod3(input logic [2*NDIG-1:0] x);
        logic [2*NDIG-1:0] res;
        logic [2:0]        s;
        int                step;
        res = x;
        for (int i = 0; i < NDIG; i++) begin
            if (res[2*i +: 2] == 2'd3) res[2*i +: 2] = 2'd0;
        end
        for (step = 1; step < NDIG; step = step * 2) begin
            for (int i = 0; i + step < NDIG; i = i + 2 * step) begin
                s = {1'b0, res[2*i +: 2]} + {1'b0, res[2*(i+step) +: 2]};
                res[2*i +: 2] = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
            end
        end
        return res[1:0];
    endfunction

    // Pick the divisor for the next trial
    always_comb begin
        unique case (i_cmd.div_sel)
            DS_D:    divisor = r_d;
            DS_D2:   divisor = r_d + VAL_W'(2);
            default: divisor = r_d;
        endcase
    end

    ptnp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (r_c[VAL_W-1:0]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Build the result for the finish command
    always_comb begin
        n_result = r_result;
        unique case (i_cmd.fin)
            FIN_TEST: n_result = '{prime_flag: i_cmd.prime, value: r_c[VAL_W-1:0],
                                   overflow: 1'b0};
            FIN_NEXT: n_result = '{prime_flag: 1'b1, value: r_c[VAL_W-1:0],
                                   overflow: 1'b0};
            FIN_TWO:  n_result = '{prime_flag: 1'b1, value: VAL_W'(2), overflow: 1'b0};
            FIN_OVF:  n_result = '{prime_flag: 1'b0, value: '0, overflow: 1'b1};
            default:  n_result = r_result;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
        // Latch the operand, clamping negatives to zero
        if (i_cmd.load) begin
            r_mode <= i_item.func;
            r_c    <= i_item.number[DATA_WIDTH-1] ? '0
                                                  : {1'b0, i_item.number[VAL_W-1:0]};
        end else if (i_cmd.inc_cand) begin
            r_c <= r_c + 1'b1;
        end
        // Advance the 6k-1 divisor
        if (i_cmd.set_d5) begin
            r_d <= VAL_W'(5);
        end else if (i_cmd.add_d6) begin
            r_d <= r_d + VAL_W'(6);
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    assign c_res3 = mod3((2*NDIG)'(r_c[VAL_W-1:0]));

    // Status back to the controller
    assign o_stat.mode     = r_mode;
    assign o_stat.c_lt2    = r_c < (VAL_W + 1)'(2);
    assign o_stat.c_le3    = r_c <= (VAL_W + 1)'(3);
    assign o_stat.c_even   = !r_c[0];
    assign o_stat.c_mult3  = c_res3 == 2'd0;
    assign o_stat.c_at_max = r_c == {1'b0, VALUE_MAX};
    assign o_stat.c_over   = r_c[VAL_W];
    assign o_stat.div_done = div_done;
    assign o_stat.rem_zero = rem == '0;
    assign o_stat.d_gt_q   = r_d > quot;

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* rtl/ptnp_ctrl.sv */
// Controller: sequences candidate checks and trial divisions.
`default_nettype none
module ptnp_ctrl
    import ptnp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CAND,
        S_LOOP,
        S_WAITA,
        S_WAITB
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   v_dec;
    logic   v_prime;

    always_comb begin
        v_dec   = 1'b0;
        v_prime = 1'b0;
        cmd     = '0;
        cmd.div_sel = DS_D;
        cmd.fin     = FIN_TEST;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            // Handle the next-mode shortcuts, else step to the first candidate
            S_DISPATCH: begin
                if (i_stat.mode == FUNC_TEST) begin
                    n_state = S_CAND;
                end else if (i_stat.c_lt2) begin
                    cmd.finish = 1'b1;
                    cmd.fin    = FIN_TWO;
                    n_state    = S_IDLE;
                end else if (i_stat.c_at_max) begin
                    cmd.finish = 1'b1;
                    cmd.fin    = FIN_OVF;
                    n_state    = S_IDLE;
                end else begin
                    cmd.inc_cand = 1'b1;
                    n_state      = S_CAND;
                end
            end
            // Overflow, small values and multiples of two or three settle at once
            S_CAND: begin
                if (i_stat.c_over) begin
                    cmd.finish = 1'b1;
                    cmd.fin    = FIN_OVF;
                    n_state    = S_IDLE;
                end else if (i_stat.c_lt2) begin
                    v_dec = 1'b1;
                end else if (i_stat.c_le3) begin
                    v_dec   = 1'b1;
                    v_prime = 1'b1;
                end else if (i_stat.c_even || i_stat.c_mult3) begin
                    v_dec = 1'b1;
                end else begin
                    cmd.set_d5 = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            // Divide by 6k-1
            S_LOOP: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DS_D;
                n_state     = S_WAITA;
            end
            // Stop once the divisor passes the square root or divides evenly, else try 6k+1
            S_WAITA: begin
                if (i_stat.div_done) begin
                    if (i_stat.d_gt_q) begin
                        v_dec   = 1'b1;
                        v_prime = 1'b1;
                    end else if (i_stat.rem_zero) begin
                        v_dec = 1'b1;
                    end else begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = DS_D2;
                        n_state     = S_WAITB;
                    end
                end
            end
            // Divide by 6k+1
            S_WAITB: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero) begin
                        v_dec = 1'b1;
                    end else begin
                        cmd.add_d6 = 1'b1;
                        n_state    = S_LOOP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Act on a verdict for the current candidate
        if (v_dec) begin
            if (i_stat.mode == FUNC_TEST) begin
                cmd.finish = 1'b1;
                cmd.fin    = FIN_TEST;
                cmd.prime  = v_prime;
                n_state    = S_IDLE;
            end else if (v_prime) begin
                cmd.finish = 1'b1;
                cmd.fin    = FIN_NEXT;
                n_state    = S_IDLE;
            end else begin
                cmd.inc_cand = 1'b1;
                n_state      = S_CAND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_state != S_IDLE;

endmodule
`default_nettype wire

/* rtl/primality_test_and_next_prime.sv */
// Top level: primality test and next-prime search by 6k+-1 trial division.
//
//  channel  | transfer when        | payload
//  ---------+----------------------+------------------------------------------
//  item in  | start && !busy       | i_item   (func, number)
//  result   | o_valid (one cycle)  | o_result (prime_flag, value, overflow)
//
// Each trial division yields all 31 quotient bits before its done status; a candidate
// past the 2/3 checks costs up to two divisions per 6k pair, at most until the 6k-1
// divisor passes sqrt(n). Next mode repeats that for every candidate up to the next
// prime. Shortcut cases (small, multiple of 2 or 3, negative, overflow) finish
// without any trial division.
// Reset is synchronous and returns the controller to idle with no result pending.
// busy stays high from the transfer in until the result strobe; results cannot stall.
`default_nettype none
module primality_test_and_next_prime
    import ptnp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out      o_result
);

    t_cmd  cmd;
    t_stat stat;

    ptnp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ptnp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTH
    // A result strobe lands only after the controller has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Strobes never come back to back
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // An accepted item always leaves the controller busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but controller not busy");

    // Overflow results carry a zero value and no prime flag
    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.overflow) |-> (!o_result.prime_flag && o_result.value == '0))
        else $error("overflow result with nonzero fields");
`endif

endmodule
`default_nettype wire

/* test/primality_test_and_next_prime_tb.sv */
// Testbench for the primality test / next-prime block: directed and random transfers.
module primality_test_and_next_prime_tb;
    import ptnp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit: a full-width prime test is the slowest run.
    // Allow several times the slowest expected run.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int          RANDOM_ITEMS = 76;
    localparam int          QUIET_TAIL = 20;
    localparam int          DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in  i_item = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    t_in  pending_items[$];
    t_out expected_results[$];
    int   items_total = 0;
    int   items_accepted = 0;
    int   test_items = 0;
    int   next_items = 0;
    int   results_seen = 0;
    int   primes_seen = 0;
    int   overflows_seen = 0;
    int   mismatch_count = 0;
    int   idle_left = 0;
    int unsigned cycle_count = 0;

    primality_test_and_next_prime u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Trial division over 6k-1 / 6k+1, bound kept as d <= n / d
    function automatic bit trial_prime(longint unsigned n);
        longint unsigned d;
        if (n <= 1) return 1'b0;
        if (n <= 3) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0) return 1'b0;
        for (d = 5; d <= n / d; d += 6) begin
            if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Compute the result the block owes for one operand
    function automatic t_out predict_result(t_in item);
        t_out            r;
        longint unsigned pos;
        longint unsigned cand;
        r = '0;
        pos = '0;
        if (!item.number[DATA_WIDTH-1]) pos[DATA_WIDTH-1:0] = item.number;
        if (item.func == FUNC_TEST) begin
            r.prime_flag = trial_prime(pos);
            r.value = pos[VAL_W-1:0];
        end else if (pos < 2) begin
            r.prime_flag = 1'b1;
            r.value = VAL_W'(2);
        end else if (pos >= VALUE_MAX) begin
            r.overflow = 1'b1;
        end else begin
            cand = pos + 1;
            while (cand <= VALUE_MAX && !trial_prime(cand)) cand++;
            if (cand > VALUE_MAX) begin
                r.overflow = 1'b1;
            end else begin
                r.prime_flag = 1'b1;
                r.value = cand[VAL_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_item(input logic func, input logic signed [DATA_WIDTH-1:0] number);
        t_in item;
        item.func = func;
        item.number = number;
        pending_items = {pending_items, item};
        items_total++;
    endtask

    // Driver: present pending items, hold until the transfer, insert idle bursts
    always @(posedge i_clk) begin
        logic fire;
        fire = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (fire) begin
                expected_results = {expected_results, predict_result(i_item)};
                items_accepted++;
                if (i_item.func == FUNC_TEST) test_items++;
                else next_items++;
                if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 16);
            end
            if (!start || fire) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    start <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_result.prime_flag) primes_seen++;
            if (o_result.overflow) overflows_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d flag=%0b ovf=%0b",
                    o_result.value, o_result.prime_flag, o_result.overflow));
            end else begin
                want = expected_results.pop_front();
                if (o_result.prime_flag !== want.prime_flag)
                    report_mismatch($sformatf("prime_flag got %0b want %0b (value want %0d)",
                        o_result.prime_flag, want.prime_flag, want.value));
                if (o_result.value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                        o_result.value, want.value));
                if (o_result.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b (value want %0d)",
                        o_result.overflow, want.overflow, want.value));
            end
        end
    end

    // Watchdog: abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic signed [DATA_WIDTH-1:0] num;
        logic                         func;
        int                           pick;

        // Test mode: small cases, squares and products of trial divisors, extremes
        queue_item(FUNC_TEST, 0);
        queue_item(FUNC_TEST, 1);
        queue_item(FUNC_TEST, 2);
        queue_item(FUNC_TEST, 3);
        queue_item(FUNC_TEST, 4);
        queue_item(FUNC_TEST, 5);
        queue_item(FUNC_TEST, 25);
        queue_item(FUNC_TEST, 35);
        queue_item(FUNC_TEST, 49);
        queue_item(FUNC_TEST, 29);
        queue_item(FUNC_TEST, -1);
        queue_item(FUNC_TEST, 32'sh8000_0000);
        queue_item(FUNC_TEST, 32'sh7fff_fffe);
        queue_item(FUNC_TEST, 32'sh3fff_ffff);
        queue_item(FUNC_TEST, 32'sh7fff_ffff);
        // Next mode: operands below two, short and long gaps, no larger prime
        queue_item(FUNC_NEXT, 32'sh8000_0000);
        queue_item(FUNC_NEXT, -1);
        queue_item(FUNC_NEXT, 0);
        queue_item(FUNC_NEXT, 1);
        queue_item(FUNC_NEXT, 2);
        queue_item(FUNC_NEXT, 3);
        queue_item(FUNC_NEXT, 23);
        queue_item(FUNC_NEXT, 113);
        queue_item(FUNC_NEXT, 32'sh7fff_ffff);

        // Random: small, medium and negative operands, large positives only where cheap to finish
        repeat (RANDOM_ITEMS) begin
            func = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                num = $urandom_range(0, 4095);
            end else if (pick < 60) begin
                num = $urandom_range(4096, 1 << 20);
            end else if (pick < 80) begin
                num = {1'b1, 31'($urandom)};
            end else begin
                // large even or multiple of three: composite, rejected early
                func = FUNC_TEST;
                num = {1'b0, 31'($urandom)};
                if ($urandom_range(0, 1)) num[0] = 1'b0;
                else num = 3 * $urandom_range(1 << 20, 32'h2aaa_aaaa);
            end
            queue_item(func, num);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(items_accepted == items_total && expected_results.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d test and %0d next transfers; %0d results, %0d prime, %0d overflow",
            test_items, next_items, results_seen, primes_seen, overflows_seen);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ptnp_pkg.sv
rtl/ptnp_div.sv
rtl/ptnp_dp.sv
rtl/ptnp_ctrl.sv
rtl/primality_test_and_next_prime.sv
test/primality_test_and_next_prime_tb.sv
